FILE: design/iss_pkg.sv
// Shared types and constants for the indexed sequence store.
`timescale 1ns / 1ps
package iss_pkg;

  // Field widths of the input and result transactions
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned IDX_W   = 6;

  // Width of positions handed to the cells; covers every supported capacity
  localparam int unsigned SEL_W = 11;

  // Traverse emits at most this many elements
  localparam int unsigned MAX_EMIT = 64;

  typedef enum logic [KIND_W-1:0] {
    K_ADD_FRONT  = 4'd0,
    K_ADD_BACK   = 4'd1,
    K_INSERT     = 4'd2,
    K_TAKE_FRONT = 4'd3,
    K_TAKE_BACK  = 4'd4,
    K_REMOVE     = 4'd5,
    K_CLEAR      = 4'd6,
    K_REVERSE    = 4'd7,
    K_TRAVERSE   = 4'd8
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_e;

  // Operation applied to every cell at once
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_REVERSE  = 2'd1,
    ST_TRAVERSE = 2'd2
  } state_e;

  // Command broadcast along the row of cells
  typedef struct packed {
    cell_op_e                op;
    logic [SEL_W-1:0]        sel;
    logic signed [VAL_W-1:0] din;
  } cell_cmd_t;

endpackage

FILE: design/iss_in_if.sv
// Input channel: operation requests.
`timescale 1ns / 1ps
interface iss_in_if import iss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

FILE: design/iss_out_if.sv
// Output channel: operation results and traversal elements.
`timescale 1ns / 1ps
interface iss_out_if import iss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [COUNT_W-1:0]      count;
  logic signed [VAL_W-1:0] item_value;
  logic [IDX_W-1:0]        item_index;
  logic                    last;

  modport source (output valid, output status, output count, output item_value,
                  output item_index, output last, input ready);
  modport sink   (input valid, input status, input count, input item_value,
                  input item_index, input last, output ready);
endinterface

FILE: design/iss_cell.sv
// One storage cell of the sequence row.
`timescale 1ns / 1ps
module iss_cell import iss_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic signed [VAL_W-1:0] prev_i,
  input  logic signed [VAL_W-1:0] next_i,
  input  logic signed [VAL_W-1:0] head_i,
  output logic signed [VAL_W-1:0] value_o
);

  localparam logic [SEL_W-1:0] IdxSel = SEL_W'(IDX);

  logic signed [VAL_W-1:0] value_q, value_d;

  // Pick the new content from the neighbors, the head or the broadcast word
  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (IdxSel > cmd_i.sel) begin
          value_d = prev_i;
        end else if (IdxSel == cmd_i.sel) begin
          value_d = cmd_i.din;
        end
      end
      OP_REMOVE: begin
        if (IdxSel >= cmd_i.sel) begin
          value_d = next_i;
        end
      end
      OP_ROTATE: begin
        if (IdxSel < cmd_i.sel) begin
          value_d = next_i;
        end else if (IdxSel == cmd_i.sel) begin
          value_d = head_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: design/iss_chain.sv
// Row of storage cells, each linked to its two neighbors and to the head.
`timescale 1ns / 1ps
module iss_chain import iss_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  output logic signed [VAL_W-1:0] head_o
);

  logic signed [VAL_W-1:0] vals [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] prev_w, next_w;

    // Ends of the row: front takes the broadcast word as predecessor, back keeps its own word
    if (g == 0) begin : g_front
      assign prev_w = cmd_i.din;
    end else begin : g_mid_prev
      assign prev_w = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_back
      assign next_w = vals[g];
    end else begin : g_mid_next
      assign next_w = vals[g+1];
    end

    iss_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_i),
      .prev_i (prev_w),
      .next_i (next_w),
      .head_i (vals[0]),
      .value_o(vals[g])
    );
  end

  assign head_o = vals[0];

endmodule

FILE: design/indexed_sequence_store.sv
// Top level of the indexed sequence store: control, count and result register.
//
//  channel | dir | payload                                   | handshake
//  in_i    | in  | kind, position, value                     | valid/ready
//  out_o   | out | status, count, item_value, item_index, last | valid/ready
//
// Push, insert, pop, remove, clear and unknown kinds finish when accepted; for the
// first four every cell shifts toward or away from the front at once.
// Reverse of two or more elements is accepted, then done by a series of rotations.
// Traverse is accepted, then rotates each held element through the front in turn.
// A result waiting on out_o.ready holds in_i.ready low and pauses a traverse.
// Reset clears the count and control; cell contents are not cleared.
`timescale 1ns / 1ps
module indexed_sequence_store import iss_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iss_in_if.sink    in_i,
  iss_out_if.source out_o
);

  localparam int unsigned HW = $clog2(CAPACITY + 1);

  state_e                  state_q, state_d;
  logic [HW-1:0]           held_q, held_d;
  logic [HW-1:0]           cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [STAT_W-1:0]       out_status_q, out_status_d;
  logic [COUNT_W-1:0]      out_count_q, out_count_d;
  logic signed [VAL_W-1:0] out_value_q, out_value_d;
  logic [IDX_W-1:0]        out_index_q, out_index_d;
  logic                    out_last_q, out_last_d;
  logic                    out_load;
  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] head;

  logic             out_free, accept, is_full, held_zero, held_many;
  logic             trav_emit, trav_step, trav_end, rev_end;
  logic [SEL_W-1:0] pos_s, held_s, ins_pos;

  // Handshake and common decodes
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;

  assign is_full   = (held_q == HW'(CAPACITY));
  assign held_zero = (held_q == '0);
  assign held_many = (held_q > HW'(1));
  assign pos_s     = SEL_W'(in_i.position);
  assign held_s    = SEL_W'(held_q);
  assign ins_pos   = (pos_s > held_s) ? held_s : pos_s;

  assign trav_emit = SEL_W'(cnt_q) < SEL_W'(MAX_EMIT);
  assign trav_step = !trav_emit || out_free;
  assign trav_end  = (cnt_q == held_q - HW'(1));
  assign rev_end   = (cnt_q == HW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_i.kind == K_REVERSE && held_many) begin
          state_d = ST_REVERSE;
        end else if (accept && in_i.kind == K_TRAVERSE && !held_zero) begin
          state_d = ST_TRAVERSE;
        end
      end
      ST_REVERSE: begin
        if (rev_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_TRAVERSE: begin
        if (trav_step && trav_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Cell commands, count and result loading
  always_comb begin
    cmd          = '{op: OP_HOLD, sel: '0, din: in_i.value};
    held_d       = held_q;
    cnt_d        = cnt_q;
    out_load     = 1'b0;
    out_status_d = STAT_DONE;
    out_value_d  = '0;
    out_index_d  = '0;
    out_last_d   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (in_i.kind)
            K_ADD_FRONT, K_ADD_BACK, K_INSERT: begin
              if (is_full) begin
                out_status_d = STAT_FULL;
              end else begin
                cmd.op = OP_INSERT;
                held_d = held_q + HW'(1);
                if (in_i.kind == K_ADD_FRONT) begin
                  cmd.sel = '0;
                end else if (in_i.kind == K_ADD_BACK) begin
                  cmd.sel = held_s;
                end else begin
                  cmd.sel = ins_pos;
                end
              end
            end
            K_TAKE_FRONT, K_TAKE_BACK: begin
              if (held_zero) begin
                out_status_d = STAT_ABSENT;
              end else begin
                cmd.op  = OP_REMOVE;
                cmd.sel = (in_i.kind == K_TAKE_FRONT) ? '0 : held_s - SEL_W'(1);
                held_d  = held_q - HW'(1);
              end
            end
            K_REMOVE: begin
              if (pos_s >= held_s) begin
                out_status_d = STAT_ABSENT;
              end else begin
                cmd.op  = OP_REMOVE;
                cmd.sel = pos_s;
                held_d  = held_q - HW'(1);
              end
            end
            K_CLEAR: begin
              held_d = '0;
            end
            K_REVERSE: begin
              if (held_many) begin
                out_load = 1'b0;
                cnt_d    = held_q - HW'(1);
              end
            end
            K_TRAVERSE: begin
              if (!held_zero) begin
                out_load = 1'b0;
                cnt_d    = '0;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_REVERSE: begin
        // Move the head behind the shrinking front part
        cmd.op  = OP_ROTATE;
        cmd.sel = SEL_W'(cnt_q);
        cnt_d   = cnt_q - HW'(1);
        out_load = rev_end;
      end
      ST_TRAVERSE: begin
        // Emit the head (for the first MAX_EMIT elements), then rotate it to the back of the held elements
        if (trav_step) begin
          cmd.op      = OP_ROTATE;
          cmd.sel     = held_s - SEL_W'(1);
          cnt_d       = cnt_q + HW'(1);
          out_load    = trav_emit;
          out_value_d = head;
          out_index_d = IDX_W'(cnt_q);
          out_last_d  = trav_end || (SEL_W'(cnt_q) == SEL_W'(MAX_EMIT - 1));
        end
      end
      default: cmd.op = OP_HOLD;
    endcase
    out_count_d = COUNT_W'(held_d);
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  iss_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .head_o(head)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
      out_value_q  <= out_value_d;
      out_index_q  <= out_index_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.count      = out_count_q;
  assign out_o.item_value = out_value_q;
  assign out_o.item_index = out_index_q;
  assign out_o.last       = out_last_q;

endmodule

FILE: design/iss_checker.sv
// Port-level checks for the indexed sequence store, bound to the top level.
`timescale 1ns / 1ps
module iss_checker import iss_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [STAT_W-1:0]  out_status_i,
  input logic [COUNT_W-1:0] out_count_i,
  input logic               out_last_i
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A new request is only taken when the result register can be refilled
  a_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("request taken while result register blocked");

  // Only defined status codes appear
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= STAT_ABSENT)
    else $error("undefined status code");

  // A rejected push only happens with the store at capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_FULL |-> out_count_i == COUNT_W'(CAPACITY))
    else $error("full status with spare room");

  // Rejected operations give a single result
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != STAT_DONE |-> out_last_i)
    else $error("error status without last flag");

endmodule

bind indexed_sequence_store iss_checker #(.CAPACITY(CAPACITY)) u_iss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_status_i(out_o.status),
  .out_count_i (out_o.count),
  .out_last_i  (out_o.last)
);

FILE: test/indexed_sequence_store_tb.sv
// Testbench for the indexed sequence store: directed table, random operation mix, scoreboard.
`timescale 1ns / 1ps
module indexed_sequence_store_tb;
  import iss_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int          CLK_PERIOD  = 8;
  localparam int          RANDOM_OPS  = 345;
  localparam int          CALM_OPS    = 50;
  localparam int          SETTLE_CYC  = 2 * CAPACITY;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;
  localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    status_e                 status;
    logic [COUNT_W-1:0]      count;
    logic signed [VAL_W-1:0] item_value;
    logic [IDX_W-1:0]        item_index;
    logic                    last;
  } result_t;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    bit                      typed;
    result_t                 want;
  } stim_row_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  iss_in_if  in_ch ();
  iss_out_if out_ch ();

  indexed_sequence_store #(.CAPACITY(CAPACITY)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Mirror of the stored sequence, front at index 0
  logic signed [VAL_W-1:0] mirror_words[$];
  // Results still owed by the block, oldest first
  result_t                 due_results[$];
  stim_row_t               directed_rows[$];
  int                      mismatches = 0;
  bit                      calm = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Apply one accepted operation to the mirror and queue the results it owes
  task automatic list_op_results(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val, input bit typed,
                                 input result_t want);
    result_t                 r;
    status_e                 st;
    logic signed [VAL_W-1:0] tmp;
    int                      lo;
    int                      hi;
    int                      n;
    st = STAT_DONE;
    case (kind)
      K_ADD_FRONT, K_ADD_BACK, K_INSERT: begin
        if (mirror_words.size() >= CAPACITY) begin
          st = STAT_FULL;
        end else if (kind == K_ADD_FRONT) begin
          mirror_words.insert(0, val);
        end else if (kind == K_ADD_BACK || pos >= mirror_words.size()) begin
          mirror_words.insert(mirror_words.size(), val);
        end else begin
          mirror_words.insert(pos, val);
        end
      end
      K_TAKE_FRONT: begin
        if (mirror_words.size() == 0) st = STAT_ABSENT;
        else mirror_words.delete(0);
      end
      K_TAKE_BACK: begin
        if (mirror_words.size() == 0) st = STAT_ABSENT;
        else mirror_words.delete(mirror_words.size() - 1);
      end
      K_REMOVE: begin
        if (pos >= mirror_words.size()) st = STAT_ABSENT;
        else mirror_words.delete(pos);
      end
      K_CLEAR: begin
        mirror_words.delete();
      end
      K_REVERSE: begin
        lo = 0;
        hi = mirror_words.size() - 1;
        while (lo < hi) begin
          tmp = mirror_words[lo];
          mirror_words[lo] = mirror_words[hi];
          mirror_words[hi] = tmp;
          lo++;
          hi--;
        end
      end
      K_TRAVERSE: begin
        // Emit up to MAX_EMIT elements front to back, flag the last one emitted
        if (mirror_words.size() != 0) begin
          n = (mirror_words.size() < MAX_EMIT) ? mirror_words.size() : MAX_EMIT;
          for (int i = 0; i < n; i++) begin
            r.status     = STAT_DONE;
            r.count      = COUNT_W'(mirror_words.size());
            r.item_value = mirror_words[i];
            r.item_index = IDX_W'(i);
            r.last       = (i == n - 1);
            due_results.insert(due_results.size(), r);
          end
          return;
        end
      end
      default: begin
      end
    endcase
    r.status     = st;
    r.count      = COUNT_W'(mirror_words.size());
    r.item_value = '0;
    r.item_index = '0;
    r.last       = 1'b1;
    due_results.insert(due_results.size(), typed ? want : r);
  endtask

  // Present one transaction from a falling edge and hold it until accepted
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input logic signed [VAL_W-1:0] val, input bit typed,
                         input result_t want);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do begin
      @(posedge clk_i);
    end while (in_ch.ready !== 1'b1);
    list_op_results(kind, pos, val, typed, want);
    @(negedge clk_i);
  endtask

  function automatic void add_row(input logic [KIND_W-1:0] kind, input int pos,
                                  input logic signed [VAL_W-1:0] val, input bit typed,
                                  input status_e st, input int cnt);
    stim_row_t row;
    row.kind            = kind;
    row.pos             = POS_W'(pos);
    row.val             = val;
    row.typed           = typed;
    row.want.status     = st;
    row.want.count      = COUNT_W'(cnt);
    row.want.item_value = '0;
    row.want.item_index = '0;
    row.want.last       = 1'b1;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Choose an operation, leaning toward growth or shrinkage by mode
  function automatic logic [KIND_W-1:0] pick_kind(input mode_e mode);
    int r;
    int add_pct;
    int rem_pct;
    r       = $urandom_range(0, 99);
    add_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 8 : 40;
    rem_pct = (mode == MODE_FILL) ? 8 : (mode == MODE_DRAIN) ? 80 : 40;
    if (r < add_pct) begin
      case ($urandom_range(0, 2))
        0:       return K_ADD_FRONT;
        1:       return K_ADD_BACK;
        default: return K_INSERT;
      endcase
    end
    r -= add_pct;
    if (r < rem_pct) begin
      case ($urandom_range(0, 2))
        0:       return K_TAKE_FRONT;
        1:       return K_TAKE_BACK;
        default: return K_REMOVE;
      endcase
    end
    r -= rem_pct;
    if (r < 5) return K_TRAVERSE;
    if (r < 9) return K_REVERSE;
    if (r < 11) return KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    return (mode == MODE_MIXED) ? K_CLEAR : K_TRAVERSE;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions that land inside the sequence, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position();
    int top;
    top = (mirror_words.size() < 63) ? mirror_words.size() : 63;
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(0, top));
  endfunction

  // Result receiver: stall in random bursts, never in the calm tail
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check each result transaction against the oldest owed result
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status     = status_e'(out_ch.status);
      got.count      = out_ch.count;
      got.item_value = out_ch.item_value;
      got.item_index = out_ch.item_index;
      got.last       = out_ch.last;
      if (due_results.size() == 0) begin
        $display("%0t ns: unexpected result: status %0d count %0d value %0d index %0d last %0d",
                 $time, got.status, got.count, got.item_value, got.item_index, got.last);
        mismatches++;
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (got.status !== want.status || got.count !== want.count ||
            got.item_value !== want.item_value || got.item_index !== want.item_index ||
            got.last !== want.last) begin
          $display("%0t ns: mismatch: expected status %0d count %0d value %0d index %0d last %0d",
                   $time, want.status, want.count, want.item_value, want.item_index,
                   want.last);
          $display("%0t ns:           actual status %0d count %0d value %0d index %0d last %0d",
                   $time, got.status, got.count, got.item_value, got.item_index, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    mode_e mode;
    int    sent;
    int    steps;
    int    episode;
    in_ch.valid    = 1'b0;
    in_ch.kind     = '0;
    in_ch.position = '0;
    in_ch.value    = '0;
    rst_ni         = 1'b0;

    // Empty store, extremes, insert corners, absent removes, unknown kinds, reverses
    add_row(K_TAKE_FRONT,   0,  '0,           1'b1, STAT_ABSENT, 0);
    add_row(K_TAKE_BACK,    0,  '0,           1'b1, STAT_ABSENT, 0);
    add_row(K_REMOVE,       0,  '0,           1'b1, STAT_ABSENT, 0);
    add_row(K_TRAVERSE,     0,  '0,           1'b1, STAT_DONE,   0);
    add_row(K_REVERSE,      0,  '0,           1'b1, STAT_DONE,   0);
    add_row(K_ADD_BACK,     63, WORD_MAX,     1'b1, STAT_DONE,   1);
    add_row(K_ADD_FRONT,    0,  WORD_MIN,     1'b1, STAT_DONE,   2);
    add_row(K_REVERSE,      0,  '0,           1'b0, STAT_DONE,   0);
    add_row(K_INSERT,       0,  '1,           1'b1, STAT_DONE,   3);
    add_row(K_INSERT,       63, '0,           1'b1, STAT_DONE,   4);
    add_row(K_INSERT,       2,  32'h5555_5555, 1'b1, STAT_DONE,  5);
    add_row(K_TRAVERSE,     0,  '0,           1'b0, STAT_DONE,   0);
    add_row(K_REMOVE,       63, '0,           1'b1, STAT_ABSENT, 5);
    add_row(K_REMOVE,       5,  '0,           1'b1, STAT_ABSENT, 5);
    add_row(K_REMOVE,       4,  '0,           1'b1, STAT_DONE,   4);
    add_row(K_REMOVE,       1,  '0,           1'b1, STAT_DONE,   3);
    add_row(KIND_UNUSED_HI, 63, '1,           1'b1, STAT_DONE,   3);
    add_row(KIND_UNUSED_LO, 0,  '0,           1'b1, STAT_DONE,   3);
    add_row(K_REVERSE,      0,  '0,           1'b1, STAT_DONE,   3);
    add_row(K_TRAVERSE,     0,  '0,           1'b0, STAT_DONE,   0);
    add_row(K_TAKE_FRONT,   0,  '0,           1'b1, STAT_DONE,   2);
    add_row(K_TAKE_BACK,    0,  '0,           1'b1, STAT_DONE,   1);
    add_row(K_REVERSE,      0,  '0,           1'b1, STAT_DONE,   1);
    add_row(K_CLEAR,        0,  '0,           1'b1, STAT_DONE,   0);
    add_row(K_TRAVERSE,     0,  '0,           1'b1, STAT_DONE,   0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].val,
              directed_rows[i].typed, directed_rows[i].want);
    end

    // Random episodes: fill toward full, drain toward empty, then randomly chosen modes
    sent    = 0;
    episode = 0;
    while (sent < RANDOM_OPS) begin
      if (episode == 0) mode = MODE_FILL;
      else if (episode == 1) mode = MODE_DRAIN;
      else mode = mode_e'($urandom_range(0, 2));
      steps = 0;
      while (sent < RANDOM_OPS &&
             !((mode == MODE_FILL && mirror_words.size() == CAPACITY) ||
               (mode == MODE_DRAIN && mirror_words.size() == 0) ||
               steps >= ((mode == MODE_MIXED) ? 30 : 150))) begin
        calm = (sent >= RANDOM_OPS - CALM_OPS);
        send_op(pick_kind(mode), pick_position(), pick_value(), 1'b0, '0);
        sent++;
        steps++;
      end
      // Press on the edges: rejected adds and a traverse when full, absent removals when empty
      if (mirror_words.size() == CAPACITY) begin
        send_op(K_ADD_BACK, pick_position(), pick_value(), 1'b0, '0);
        send_op(K_INSERT, pick_position(), pick_value(), 1'b0, '0);
        send_op(K_TRAVERSE, pick_position(), pick_value(), 1'b0, '0);
        sent += 3;
      end else if (mirror_words.size() == 0) begin
        send_op(K_TAKE_FRONT, pick_position(), pick_value(), 1'b0, '0);
        send_op(K_TAKE_BACK, pick_position(), pick_value(), 1'b0, '0);
        send_op(K_REMOVE, pick_position(), pick_value(), 1'b0, '0);
        sent += 3;
      end
      // Hold the sender once until every owed result has drained
      if (episode == 1) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
        while (due_results.size() != 0) @(negedge clk_i);
      end
      episode++;
    end

    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Bound the run in case the block stops responding
  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
